@@ hw/rtl/css_pkg.sv @@
package css_pkg;

  localparam int HEAD_W      = 64;
  localparam int TAIL_W      = 16;
  localparam int STR_BYTES   = 10;
  localparam int LEN_W       = 4;
  localparam int ALL_COLUMNS = 5;

  // The length sits above the characters, so a plain unsigned compare of two
  // entries orders them by length first and by byte order second.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SORT_INIT,
    S_SORT_FIRST,
    S_SORT_CMP,
    S_SORT_END,
    S_EMIT_RD,
    S_EMIT_CAP,
    S_EMIT_OUT
  } state_t;

endpackage

@@ hw/rtl/column_string_sorter.sv @@
// Each row is stored one column at a time; the block takes no new row meanwhile.
// After the last row, each column of n rows is bubble sorted through one comparator and
// the entry RAM, which has one write port and one registered read port.
// Each sorted row is gathered from the RAM one column at a time and is shown next.
// Reset clears the sequencer, the row count and the overflow flag; the RAM is not cleared.
module column_string_sorter #(
  parameter int MAX_ROWS    = 16,
  parameter int NUM_COLUMNS = 5,
  parameter int MAX_CHARS   = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] col0_head,
  input  logic [15:0] col0_tail,
  input  logic [63:0] col1_head,
  input  logic [15:0] col1_tail,
  input  logic [63:0] col2_head,
  input  logic [15:0] col2_tail,
  input  logic [63:0] col3_head,
  input  logic [15:0] col3_tail,
  input  logic [63:0] col4_head,
  input  logic [15:0] col4_tail,
  input  logic        last_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out0_head,
  output logic [15:0] out0_tail,
  output logic [63:0] out1_head,
  output logic [15:0] out1_tail,
  output logic [63:0] out2_head,
  output logic [15:0] out2_tail,
  output logic [63:0] out3_head,
  output logic [15:0] out3_tail,
  output logic [63:0] out4_head,
  output logic [15:0] out4_tail,
  output logic        final_out,
  output logic        overflowed
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CNTW = $clog2(MAX_ROWS + 1);
  localparam int CW   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int AW   = CW + RW;
  localparam logic [CW-1:0] COL_LAST = CW'(NUM_COLUMNS - 1);

  css_pkg::state_t state, state_next;

  logic [CW-1:0]   col, col_next;
  logic [RW-1:0]   j, j_next;
  logic [RW-1:0]   limit, limit_next;
  logic [RW-1:0]   k, k_next;
  logic [CNTW-1:0] row_count, row_count_next;
  logic            overflow_seen, overflow_seen_next;
  logic            last_flag;
  css_pkg::entry_t carry, carry_next;

  logic [css_pkg::HEAD_W-1:0] in_head [css_pkg::ALL_COLUMNS];
  logic [css_pkg::TAIL_W-1:0] in_tail [css_pkg::ALL_COLUMNS];
  logic [css_pkg::HEAD_W-1:0] raw_head [NUM_COLUMNS];
  logic [css_pkg::TAIL_W-1:0] raw_tail [NUM_COLUMNS];
  logic [css_pkg::HEAD_W-1:0] sorted_head [NUM_COLUMNS];
  logic [css_pkg::TAIL_W-1:0] sorted_tail [NUM_COLUMNS];
  logic [css_pkg::HEAD_W-1:0] head_bus [css_pkg::ALL_COLUMNS];
  logic [css_pkg::TAIL_W-1:0] tail_bus [css_pkg::ALL_COLUMNS];

  logic            in_take;
  logic            cap_en;
  logic            is_final;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  css_pkg::entry_t wr_data;
  css_pkg::entry_t rd_data;
  css_pkg::entry_t norm_entry;

  assign in_head[0] = col0_head;
  assign in_head[1] = col1_head;
  assign in_head[2] = col2_head;
  assign in_head[3] = col3_head;
  assign in_head[4] = col4_head;
  assign in_tail[0] = col0_tail;
  assign in_tail[1] = col1_tail;
  assign in_tail[2] = col2_tail;
  assign in_tail[3] = col3_tail;
  assign in_tail[4] = col4_tail;

  css_norm #(
    .MAX_CHARS(MAX_CHARS)
  ) u_norm (
    .head (raw_head[col]),
    .tail (raw_tail[col]),
    .entry(norm_entry)
  );

  css_ram #(
    .AW(AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_take  = in_valid && (state == css_pkg::S_IDLE);
  assign is_final = (CNTW'(k) + CNTW'(1)) == row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= css_pkg::S_IDLE;
      row_count     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      row_count     <= row_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    col   <= col_next;
    j     <= j_next;
    limit <= limit_next;
    k     <= k_next;
    carry <= carry_next;
    if (in_take) begin
      last_flag <= last_row;
    end
  end

  for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_col
    always_ff @(posedge clk) begin
      if (in_take) begin
        raw_head[c] <= in_head[c];
        raw_tail[c] <= in_tail[c];
      end
      if (cap_en && (col == CW'(c))) begin
        sorted_head[c] <= rd_data.head;
        sorted_tail[c] <= rd_data.tail;
      end
    end
  end

  for (genvar c = 0; c < css_pkg::ALL_COLUMNS; c++) begin : g_out
    if (c < NUM_COLUMNS) begin : g_used
      assign head_bus[c] = sorted_head[c];
      assign tail_bus[c] = sorted_tail[c];
    end else begin : g_unused
      assign head_bus[c] = '0;
      assign tail_bus[c] = '0;
    end
  end

  assign out0_head  = head_bus[0];
  assign out0_tail  = tail_bus[0];
  assign out1_head  = head_bus[1];
  assign out1_tail  = tail_bus[1];
  assign out2_head  = head_bus[2];
  assign out2_tail  = tail_bus[2];
  assign out3_head  = head_bus[3];
  assign out3_tail  = tail_bus[3];
  assign out4_head  = head_bus[4];
  assign out4_tail  = tail_bus[4];
  assign final_out  = is_final;
  assign overflowed = overflow_seen;

  // Each sort pass carries the larger entry along the column and writes the
  // smaller one back behind it, so the largest ends at the top of the pass.
  always_comb begin
    state_next         = state;
    col_next           = col;
    j_next             = j;
    limit_next         = limit;
    k_next             = k;
    row_count_next     = row_count;
    overflow_seen_next = overflow_seen;
    carry_next         = carry;
    in_stall           = 1'b1;
    out_valid          = 1'b0;
    cap_en             = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = {col, row_count[RW-1:0]};
    wr_data            = norm_entry;
    rd_addr            = {col, j};
    unique case (state)
      css_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          col_next = '0;
          if (row_count < CNTW'(MAX_ROWS)) begin
            state_next = css_pkg::S_LOAD;
          end else begin
            overflow_seen_next = 1'b1;
            if (last_row) begin
              state_next = css_pkg::S_SORT_INIT;
            end
          end
        end
      end
      css_pkg::S_LOAD: begin
        wr_en = 1'b1;
        if (col == COL_LAST) begin
          row_count_next = row_count + CNTW'(1);
          state_next     = last_flag ? css_pkg::S_SORT_INIT : css_pkg::S_IDLE;
        end else begin
          col_next = col + 1'b1;
        end
      end
      css_pkg::S_SORT_INIT: begin
        col_next = '0;
        k_next   = '0;
        rd_addr  = {CW'(0), RW'(0)};
        if (row_count == CNTW'(0)) begin
          overflow_seen_next = 1'b0;
          state_next         = css_pkg::S_IDLE;
        end else if (row_count == CNTW'(1)) begin
          state_next = css_pkg::S_EMIT_RD;
        end else begin
          limit_next = RW'(row_count - CNTW'(1));
          state_next = css_pkg::S_SORT_FIRST;
        end
      end
      css_pkg::S_SORT_FIRST: begin
        carry_next = rd_data;
        j_next     = RW'(1);
        rd_addr    = {col, RW'(1)};
        state_next = css_pkg::S_SORT_CMP;
      end
      css_pkg::S_SORT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = {col, j - 1'b1};
        if (carry > rd_data) begin
          wr_data = rd_data;
        end else begin
          wr_data    = carry;
          carry_next = rd_data;
        end
        if (j == limit) begin
          state_next = css_pkg::S_SORT_END;
        end else begin
          j_next  = j + 1'b1;
          rd_addr = {col, j + 1'b1};
        end
      end
      css_pkg::S_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = {col, limit};
        wr_data = carry;
        rd_addr = {col, RW'(0)};
        if (limit == RW'(1)) begin
          if (col == COL_LAST) begin
            col_next   = '0;
            k_next     = '0;
            state_next = css_pkg::S_EMIT_RD;
          end else begin
            col_next   = col + 1'b1;
            limit_next = RW'(row_count - CNTW'(1));
            rd_addr    = {col + 1'b1, RW'(0)};
            state_next = css_pkg::S_SORT_FIRST;
          end
        end else begin
          limit_next = limit - 1'b1;
          state_next = css_pkg::S_SORT_FIRST;
        end
      end
      css_pkg::S_EMIT_RD: begin
        rd_addr    = {col, k};
        state_next = css_pkg::S_EMIT_CAP;
      end
      css_pkg::S_EMIT_CAP: begin
        cap_en = 1'b1;
        if (col == COL_LAST) begin
          state_next = css_pkg::S_EMIT_OUT;
        end else begin
          col_next   = col + 1'b1;
          state_next = css_pkg::S_EMIT_RD;
        end
      end
      css_pkg::S_EMIT_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (is_final) begin
            row_count_next     = '0;
            overflow_seen_next = 1'b0;
            state_next         = css_pkg::S_IDLE;
          end else begin
            k_next     = k + 1'b1;
            col_next   = '0;
            state_next = css_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = css_pkg::S_IDLE;
      end
    endcase
  end

  a_out_row_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_count != CNTW'(0)) && (CNTW'(k) < row_count))
    else $error("sorted row index outside the stored rows");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_out) |=> (row_count == CNTW'(0)) && !overflow_seen)
    else $error("run state not cleared after the final transaction");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (row_count == CNTW'(MAX_ROWS)))
    else $error("overflow flagged while the store is not full");

  a_sort_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == css_pkg::S_SORT_CMP) |->
      (j != RW'(0)) && (j <= limit) && (CNTW'(limit) < row_count))
    else $error("sort pass index beyond the stored rows");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNTW'(MAX_ROWS))
    else $error("row count above capacity");

endmodule

@@ hw/rtl/css_norm.sv @@
module css_norm #(
  parameter int MAX_CHARS = 10
) (
  input  logic [css_pkg::HEAD_W-1:0] head,
  input  logic [css_pkg::TAIL_W-1:0] tail,
  output css_pkg::entry_t            entry
);

  localparam int FLAT_W = css_pkg::HEAD_W + css_pkg::TAIL_W;

  logic [FLAT_W-1:0]         flat;
  logic [FLAT_W-1:0]         mask;
  logic [css_pkg::LEN_W-1:0] len;

  assign flat = {head, tail};

  // A character is kept only while it and every earlier one are nonzero and the
  // position is within the character limit.
  always_comb begin
    logic run;
    run  = 1'b1;
    mask = '0;
    len  = '0;
    for (int i = 0; i < css_pkg::STR_BYTES; i++) begin
      run = run && (i < MAX_CHARS) && (flat[FLAT_W-1-8*i -: 8] != 8'h00);
      if (run) begin
        mask[FLAT_W-1-8*i -: 8] = 8'hFF;
        len = css_pkg::LEN_W'(i + 1);
      end
    end
  end

  assign entry.len  = len;
  assign entry.head = flat[FLAT_W-1 -: css_pkg::HEAD_W] & mask[FLAT_W-1 -: css_pkg::HEAD_W];
  assign entry.tail = flat[css_pkg::TAIL_W-1:0] & mask[css_pkg::TAIL_W-1:0];

endmodule

@@ hw/rtl/css_ram.sv @@
module css_ram #(
  parameter int AW = 7
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  css_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output css_pkg::entry_t rd_data
);

  css_pkg::entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ROWS     = 16;
  localparam int NUM_COLS     = 5;
  localparam int MAX_CHARS    = 10;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_LEN     = 1500;
  localparam int SETTLE       = 200;
  localparam int RANDOM_ROWS  = 110;

  typedef struct packed {
    logic [NUM_COLS-1:0][63:0] head;
    logic [NUM_COLS-1:0][15:0] tail;
    logic                      last;
  } row_t;

  typedef struct packed {
    logic [NUM_COLS-1:0][63:0] head;
    logic [NUM_COLS-1:0][15:0] tail;
    logic                      fin;
    logic                      ovf;
  } sorted_row_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] head;
    logic [15:0] tail;
  } str_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] col0_head = '0;
  logic [15:0] col0_tail = '0;
  logic [63:0] col1_head = '0;
  logic [15:0] col1_tail = '0;
  logic [63:0] col2_head = '0;
  logic [15:0] col2_tail = '0;
  logic [63:0] col3_head = '0;
  logic [15:0] col3_tail = '0;
  logic [63:0] col4_head = '0;
  logic [15:0] col4_tail = '0;
  logic        last_row = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out0_head;
  logic [15:0] out0_tail;
  logic [63:0] out1_head;
  logic [15:0] out1_tail;
  logic [63:0] out2_head;
  logic [15:0] out2_tail;
  logic [63:0] out3_head;
  logic [15:0] out3_tail;
  logic [63:0] out4_head;
  logic [15:0] out4_tail;
  logic        final_out;
  logic        overflowed;

  row_t        rows_pending[$];
  sorted_row_t sorted_due[$];
  row_t        drv_row;
  row_t        taken_row;
  sorted_row_t got_row;
  sorted_row_t want_row;

  str_t column_store[MAX_ROWS][NUM_COLS];
  int   stored_rows = 0;
  bit   dropped = 1'b0;

  bit   in_taken = 1'b0;
  bit   hold_go = 1'b0;
  int   hold_left = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   rows_queued = 0;
  int   rows_taken = 0;
  int   rows_checked = 0;
  int   sets_done = 0;
  int   overflow_sets = 0;
  int   errors = 0;
  int   cycle_count = 0;

  int   send_idle_by_phase[4] = '{0, 68, 0, 29};
  int   recv_stall_by_phase[4] = '{0, 0, 68, 29};

  column_string_sorter #(
    .MAX_ROWS   (MAX_ROWS),
    .NUM_COLUMNS(NUM_COLS),
    .MAX_CHARS  (MAX_CHARS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .col0_head (col0_head),
    .col0_tail (col0_tail),
    .col1_head (col1_head),
    .col1_tail (col1_tail),
    .col2_head (col2_head),
    .col2_tail (col2_tail),
    .col3_head (col3_head),
    .col3_tail (col3_tail),
    .col4_head (col4_head),
    .col4_tail (col4_tail),
    .last_row  (last_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out0_head (out0_head),
    .out0_tail (out0_tail),
    .out1_head (out1_head),
    .out1_tail (out1_tail),
    .out2_head (out2_head),
    .out2_tail (out2_tail),
    .out3_head (out3_head),
    .out3_tail (out3_tail),
    .out4_head (out4_head),
    .out4_tail (out4_tail),
    .final_out (final_out),
    .overflowed(overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic str_t trim_string(input logic [63:0] h, input logic [15:0] t);
    logic [79:0] raw;
    logic [79:0] keep;
    str_t        s;
    int          n;
    raw = {h, t};
    n = 0;
    while (n < MAX_CHARS && raw[79 - 8*n -: 8] != 8'h00) n++;
    keep = ~({80{1'b1}} >> (8*n));
    s.len = 4'(n);
    {s.head, s.tail} = raw & keep;
    return s;
  endfunction

  task automatic absorb_row(input row_t r);
    str_t        tmp;
    sorted_row_t s;
    int          c, i, j, k, n;
    if (stored_rows < MAX_ROWS) begin
      for (c = 0; c < NUM_COLS; c++)
        column_store[stored_rows][c] = trim_string(r.head[c], r.tail[c]);
      stored_rows++;
    end else begin
      dropped = 1'b1;
    end
    if (r.last) begin
      n = stored_rows;
      for (c = 0; c < NUM_COLS; c++) begin
        for (i = 0; i + 1 < n; i++) begin
          for (j = 0; j + 1 < n - i; j++) begin
            if ({column_store[j][c].len, column_store[j][c].head, column_store[j][c].tail} >
                {column_store[j+1][c].len, column_store[j+1][c].head,
                 column_store[j+1][c].tail}) begin
              tmp = column_store[j][c];
              column_store[j][c] = column_store[j+1][c];
              column_store[j+1][c] = tmp;
            end
          end
        end
      end
      for (k = 0; k < n; k++) begin
        for (c = 0; c < NUM_COLS; c++) begin
          s.head[c] = column_store[k][c].head;
          s.tail[c] = column_store[k][c].tail;
        end
        s.fin = (k == n - 1);
        s.ovf = dropped;
        sorted_due.push_back(s);
      end
      sets_done++;
      if (dropped) overflow_sets++;
      stored_rows = 0;
      dropped = 1'b0;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (rows_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_row = rows_pending.pop_front();
        col0_head <= drv_row.head[0];
        col0_tail <= drv_row.tail[0];
        col1_head <= drv_row.head[1];
        col1_tail <= drv_row.tail[1];
        col2_head <= drv_row.head[2];
        col2_tail <= drv_row.tail[2];
        col3_head <= drv_row.head[3];
        col3_tail <= drv_row.tail[3];
        col4_head <= drv_row.head[4];
        col4_tail <= drv_row.tail[4];
        last_row  <= drv_row.last;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      taken_row.head = {col4_head, col3_head, col2_head, col1_head, col0_head};
      taken_row.tail = {col4_tail, col3_tail, col2_tail, col1_tail, col0_tail};
      taken_row.last = last_row;
      absorb_row(taken_row);
      rows_taken++;
    end
    if (!rst && out_valid && !out_stall) begin
      got_row.head = {out4_head, out3_head, out2_head, out1_head, out0_head};
      got_row.tail = {out4_tail, out3_tail, out2_tail, out1_tail, out0_tail};
      got_row.fin  = final_out;
      got_row.ovf  = overflowed;
      if (sorted_due.size() == 0) begin
        $error("sorted row transaction with none expected");
        errors++;
      end else begin
        want_row = sorted_due.pop_front();
        for (int c = 0; c < NUM_COLS; c++) begin
          if (got_row.head[c] !== want_row.head[c]) begin
            $error("out%0d_head expected %h actual %h", c, want_row.head[c], got_row.head[c]);
            errors++;
          end
          if (got_row.tail[c] !== want_row.tail[c]) begin
            $error("out%0d_tail expected %h actual %h", c, want_row.tail[c], got_row.tail[c]);
            errors++;
          end
        end
        if (got_row.fin !== want_row.fin) begin
          $error("final_out expected %b actual %b", want_row.fin, got_row.fin);
          errors++;
        end
        if (got_row.ovf !== want_row.ovf) begin
          $error("overflowed expected %b actual %b", want_row.ovf, got_row.ovf);
          errors++;
        end
        rows_checked++;
      end
    end
  end

  function automatic logic [79:0] make_field(input bit tight);
    logic [79:0] raw;
    int          n, i;
    raw = '0;
    n = tight ? $urandom_range(1, 3) : $urandom_range(0, MAX_CHARS);
    for (i = 0; i < n; i++)
      raw[79 - 8*i -: 8] = tight ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(1, 255));
    if (n < 9 && $urandom_range(0, 1) == 1)
      for (i = n + 1; i < 10; i++) raw[79 - 8*i -: 8] = 8'($urandom_range(0, 255));
    return raw;
  endfunction

  function automatic row_t make_row(input bit last);
    row_t        r;
    logic [79:0] f;
    bit          tight, noise;
    tight = ($urandom_range(0, 3) == 0);
    noise = ($urandom_range(0, 9) == 0);
    for (int c = 0; c < NUM_COLS; c++) begin
      f = noise ? {$urandom, $urandom, 16'($urandom)} : make_field(tight);
      {r.head[c], r.tail[c]} = f;
    end
    r.last = last;
    return r;
  endfunction

  function automatic row_t row_of(input logic [79:0] f0, f1, f2, f3, f4, input bit last);
    row_t r;
    {r.head[0], r.tail[0]} = f0;
    {r.head[1], r.tail[1]} = f1;
    {r.head[2], r.tail[2]} = f2;
    {r.head[3], r.tail[3]} = f3;
    {r.head[4], r.tail[4]} = f4;
    r.last = last;
    return r;
  endfunction

  task automatic push_row(input row_t r);
    rows_pending.push_back(r);
    rows_queued++;
  endtask

  task automatic queue_set(input int n);
    for (int i = 0; i < n; i++) push_row(make_row(i == n - 1));
  endtask

  task automatic run_random(input int quota);
    int sent, p, n;
    sent = 0;
    while (sent < quota) begin
      p = $urandom_range(0, 99);
      if (p < 65) n = $urandom_range(1, 8);
      else if (p < 85) n = $urandom_range(9, MAX_ROWS);
      else if (p < 90) n = MAX_ROWS;
      else n = $urandom_range(MAX_ROWS + 1, MAX_ROWS + 4);
      queue_set(n);
      sent += n;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (rows_taken != rows_queued || sorted_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[column_string_sorter] ERROR");
    $finish;
  end

  initial begin
    logic [79:0] all1, emb, one, l8, l8j, l9, l10, lead0, zero;
    all1  = {80{1'b1}};
    emb   = 80'h4100_4243_4445_4647_4849;
    one   = 80'h4100_0000_0000_0000_0000;
    l8    = 80'h4142_4344_4546_4748_0000;
    l8j   = 80'h4142_4344_4546_4748_00FF;
    l9    = 80'h4142_4344_4546_4748_4900;
    l10   = 80'h4142_4344_4546_4748_494A;
    lead0 = 80'h00FF_FFFF_FFFF_FFFF_FFFF;
    zero  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      send_idle_pct = send_idle_by_phase[p];
      recv_stall_pct = recv_stall_by_phase[p];
      if (p == 0) begin
        push_row(row_of(zero, zero, zero, zero, zero, 1'b1));
        push_row(row_of(all1, emb, l8, zero, l10, 1'b0));
        push_row(row_of(zero, one, l8j, lead0, l9, 1'b0));
        push_row(row_of(l10, l9, all1, one, zero, 1'b0));
        push_row(row_of(emb, emb, zero, l8, all1, 1'b0));
        push_row(row_of(l9, lead0, one, all1, l8j, 1'b0));
        push_row(row_of(one, zero, l10, emb, lead0, 1'b1));
        queue_set(MAX_ROWS + 2);
        wait_drained();
        @(posedge clk);
        run_random(RANDOM_ROWS);
        @(negedge clk) hold_go <= 1'b1;
        @(negedge clk) hold_go <= 1'b0;
      end else begin
        run_random(RANDOM_ROWS);
      end
      wait_drained();
    end
    if (sorted_due.size() != 0) begin
      $error("%0d sorted rows never arrived", sorted_due.size());
      errors++;
    end
    $display("Sorted %0d row sets (%0d of them with dropped rows) from %0d rows; %0d sorted rows compared.",
             sets_done, overflow_sets, rows_taken, rows_checked);
    $display("Idle patterns covered: none, sender only, receiver only, both, and one long output hold-off.");
    if (errors == 0) begin
      $display("[column_string_sorter] OK");
    end else begin
      $display("[column_string_sorter] ERROR");
    end
    $finish;
  end

endmodule
